// ===== rtl/mch_pkg.sv =====
package mch_pkg;

  localparam int BIN_BITS_DEF   = 4;
  localparam int COUNT_BITS_DEF = 24;
  localparam int CHAN_BITS      = 8;
  localparam int OUT_BITS       = 24;

  localparam logic [CHAN_BITS-1:0] SELECT_MARK = 8'hFF;
  localparam logic [OUT_BITS-1:0]  OUT_MAX     = 24'hFF_FFFF;

  localparam logic CMD_LEARN = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

endpackage

// ===== rtl/mch_if.sv =====
interface mch_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic                          frame_start;
  logic [mch_pkg::CHAN_BITS-1:0] pixel_selected;
  logic [mch_pkg::CHAN_BITS-1:0] chan_a;
  logic [mch_pkg::CHAN_BITS-1:0] chan_b;
  logic [mch_pkg::CHAN_BITS-1:0] chan_c;

  modport source (output valid, cmd, frame_start, pixel_selected, chan_a, chan_b, chan_c,
                  input ready);
  modport sink   (input valid, cmd, frame_start, pixel_selected, chan_a, chan_b, chan_c,
                  output ready);
endinterface

interface mch_out_if;
  logic                         valid;
  logic                         ready;
  logic [mch_pkg::OUT_BITS-1:0] bin_count;
  logic [mch_pkg::OUT_BITS-1:0] total_pixels;

  modport source (output valid, bin_count, total_pixels, input ready);
  modport sink   (input valid, bin_count, total_pixels, output ready);
endinterface

// ===== rtl/masked_color_histogram.sv =====
// Masked 3-D color histogram. Each channel keeps its top BIN_BITS bits, giving
// 2^(3*BIN_BITS) bins held as COUNT_BITS-bit saturating counters in one
// synchronous RAM, plus a saturating pixel total. A learn item (cmd 0) whose
// mask byte is 255 bumps its bin and the total; a learn item with frame_start
// first clears all bins and the total. A query (cmd 1) returns the bin count
// and the total, each clamped to 24 bits. Throughput: one item per cycle in
// steady state (no sweep, no waiting query) through a two-stage
// read-modify-write on the RAM port (read at accept, write in the following
// cycle, with a forwarding register for back-to-back hits on one bin). A
// query waits while an earlier result is still held in the output register.
// A frame-start item and reset each start a clearing sweep over all
// 2^(3*BIN_BITS) bins (4096 at BIN_BITS = 4), one bin per cycle, during which
// no item is accepted; the frame-start pixel is folded into that sweep. A
// query's result waits in the output register until the receiver takes it.
module masked_color_histogram #(
  parameter int BIN_BITS   = mch_pkg::BIN_BITS_DEF,
  parameter int COUNT_BITS = mch_pkg::COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mch_in_if.sink    in_ch,
  mch_out_if.source out_ch
);

  localparam int ADDR_BITS = 3 * BIN_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // saturating increment
  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
    bump = (v == COUNT_MAX) ? v : v + COUNT_BITS'(1);
  endfunction

  // clamp to the 24-bit result field
  function automatic logic [mch_pkg::OUT_BITS-1:0] report(input logic [COUNT_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    report = (w > 32'(mch_pkg::OUT_MAX)) ? mch_pkg::OUT_MAX : w[mch_pkg::OUT_BITS-1:0];
  endfunction

  // input decode
  logic                 in_acc;
  logic                 start_acc;
  logic                 item_acc;
  logic                 in_sel;
  logic [ADDR_BITS-1:0] in_idx;

  // stage 1: item waiting on RAM read data
  logic                 s1_v_r, s1_v_nxt;
  logic                 s1_query_r;
  logic                 s1_sel_r;
  logic [ADDR_BITS-1:0] s1_idx_r;
  logic                 s1_adv;
  logic                 s1_wr;
  logic [COUNT_BITS-1:0] s1_cur;
  logic [COUNT_BITS-1:0] s1_new;

  // forwarding of a write that lands on the same edge as the read
  logic                  fwd_hit_r;
  logic [COUNT_BITS-1:0] fwd_data_r;

  // clearing sweep
  logic                 clr_busy_r, clr_busy_nxt;
  logic [ADDR_BITS-1:0] clr_addr_r, clr_addr_nxt;
  logic [ADDR_BITS-1:0] tgt_idx_r;
  logic                 tgt_sel_r;

  // totals and output register
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_load;
  logic [mch_pkg::OUT_BITS-1:0] out_bin_r;
  logic [mch_pkg::OUT_BITS-1:0] out_tot_r;

  // RAM port
  logic                  ram_wr_en;
  logic [ADDR_BITS-1:0]  ram_wr_addr;
  logic [COUNT_BITS-1:0] ram_wr_data;
  logic [COUNT_BITS-1:0] ram_rd_data;

  assign in_idx = {in_ch.chan_a[mch_pkg::CHAN_BITS-1 -: BIN_BITS],
                   in_ch.chan_b[mch_pkg::CHAN_BITS-1 -: BIN_BITS],
                   in_ch.chan_c[mch_pkg::CHAN_BITS-1 -: BIN_BITS]};
  assign in_sel = (in_ch.pixel_selected == mch_pkg::SELECT_MARK);

  // hold stage 1 only when a query must wait on a full output register
  assign s1_adv      = !s1_v_r || (s1_query_r != mch_pkg::CMD_QUERY) ||
                       !out_valid_r || out_ch.ready;
  assign in_ch.ready = !clr_busy_r && s1_adv;
  assign in_acc      = in_ch.valid && in_ch.ready;
  // frame start on a learn item goes to the sweep, not to stage 1
  assign start_acc   = in_acc && (in_ch.cmd == mch_pkg::CMD_LEARN) && in_ch.frame_start;
  assign item_acc    = in_acc && !start_acc;

  assign s1_cur = fwd_hit_r ? fwd_data_r : ram_rd_data;
  assign s1_new = bump(s1_cur);
  assign s1_wr  = s1_v_r && (s1_query_r == mch_pkg::CMD_LEARN) && s1_sel_r;

  assign s1_v_nxt = item_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  // capture the item and the forward path at accept
  always_ff @(posedge clk) begin
    if (item_acc) begin
      s1_query_r <= in_ch.cmd;
      s1_sel_r   <= in_sel;
      s1_idx_r   <= in_idx;
      fwd_hit_r  <= s1_wr && (s1_idx_r == in_idx);
      fwd_data_r <= s1_new;
    end
  end

  // sweep: reset starts one, a frame-start item starts another
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_BITS'(1);
      if (clr_addr_r == '1) begin
        clr_busy_nxt = 1'b0;
      end
    end else if (start_acc) begin
      clr_busy_nxt = 1'b1;
      clr_addr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      tgt_sel_r  <= 1'b0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (start_acc) begin
        tgt_sel_r <= in_sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_acc) begin
      tgt_idx_r <= in_idx;
    end
  end

  // the pixel of a selected frame-start item lands as a count of one during the sweep
  always_comb begin
    if (clr_busy_r) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = clr_addr_r;
      ram_wr_data = (tgt_sel_r && (clr_addr_r == tgt_idx_r)) ? COUNT_BITS'(1) : '0;
    end else begin
      ram_wr_en   = s1_wr;
      ram_wr_addr = s1_idx_r;
      ram_wr_data = s1_new;
    end
  end

  // frame start wins over a bump from the item ahead of it
  always_comb begin
    total_nxt = total_r;
    if (start_acc) begin
      total_nxt = in_sel ? COUNT_BITS'(1) : '0;
    end else if (s1_wr) begin
      total_nxt = bump(total_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

  // output register
  assign out_load      = s1_v_r && (s1_query_r == mch_pkg::CMD_QUERY) && s1_adv;
  assign out_valid_nxt = out_load ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bin_r <= report(s1_cur);
      out_tot_r <= report(total_r);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.bin_count    = out_bin_r;
  assign out_ch.total_pixels = out_tot_r;

  mch_bin_ram #(
    .ADDR_BITS(ADDR_BITS),
    .DATA_BITS(COUNT_BITS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(ram_wr_addr),
    .wr_data(ram_wr_data),
    .rd_en  (item_acc),
    .rd_addr(in_idx),
    .rd_data(ram_rd_data)
  );

  // a frame-start item launches a sweep from bin zero
  a_start_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    start_acc |=> (clr_busy_r && (clr_addr_r == '0)))
    else $error("frame start did not launch a clearing sweep");

  // the sweep and a pending item never share the RAM write port
  a_sweep_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(clr_busy_r && s1_v_r))
    else $error("stage 1 busy during clearing sweep");

  // a new result only comes from a query leaving stage 1
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_v_r && (s1_query_r == mch_pkg::CMD_QUERY)))
    else $error("result raised without a query");

  // the total only falls on a frame start
  a_total_mono: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$past(start_acc)) |-> (total_r >= $past(total_r)))
    else $error("pixel total decreased without frame start");

endmodule

// ===== rtl/mch_bin_ram.sv =====
module mch_bin_ram #(
  parameter int ADDR_BITS = 12,
  parameter int DATA_BITS = 24
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  // write and registered read; a same-edge read returns the old word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== verif/masked_color_histogram_tb.sv =====
module masked_color_histogram_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Geometry of the histogram under test (default parameters of the block).
  localparam int BIN_BITS   = mch_pkg::BIN_BITS_DEF;
  localparam int COUNT_BITS = mch_pkg::COUNT_BITS_DEF;
  localparam int CHAN_BITS  = mch_pkg::CHAN_BITS;
  localparam int OUT_BITS   = mch_pkg::OUT_BITS;
  localparam int IDX_BITS   = 3 * BIN_BITS;
  localparam int NUM_BINS   = 1 << IDX_BITS;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  // Channel bits that pick the bin, and the bits that vary inside one bin.
  localparam logic [CHAN_BITS-1:0] BIN_MASK = 8'hFF << (CHAN_BITS - BIN_BITS);

  // Longest stretch with no item moving on either side. A clearing sweep
  // (reset or frame start) blocks the input while it visits every bin; the
  // long receiver hold-off and random gaps add far less than the margin here.
  localparam int STALL_LIMIT = 5 * NUM_BINS;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [OUT_BITS-1:0] bin_count;
    logic [OUT_BITS-1:0] total_pixels;
  } hist_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mch_in_if  in_ch ();
  mch_out_if out_ch ();

  masked_color_histogram DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // Shadow copy of the histogram, updated at each accepted item.
  logic [COUNT_BITS-1:0] hist_bins [NUM_BINS];
  logic [COUNT_BITS-1:0] pixel_count;
  hist_reply_t           pending_replies [$];

  int fail_count   = 0;
  int src_idle_pct = 0;  // chance in 100 that the sender skips a cycle
  int snk_idle_pct = 0;  // chance in 100 that the receiver drops ready
  int holdoff_left = 0;  // cycles the receiver still holds ready low

  task automatic note_failure(input string what, input logic [31:0] exp_v,
                              input logic [31:0] got_v);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %s: expected %0d, actual %0d", what, exp_v, got_v);
  endtask

  function automatic void clear_histogram();
    foreach (hist_bins[i]) hist_bins[i] = '0;
    pixel_count = '0;
  endfunction

  function automatic logic [IDX_BITS-1:0] bin_index(input logic [CHAN_BITS-1:0] a, b, c);
    return {a[CHAN_BITS-1 -: BIN_BITS], b[CHAN_BITS-1 -: BIN_BITS],
            c[CHAN_BITS-1 -: BIN_BITS]};
  endfunction

  // Counters stick at full scale instead of wrapping.
  function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
    return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_BITS'(1);
  endfunction

  // Reported values are clamped to the 24-bit result fields.
  function automatic logic [OUT_BITS-1:0] clamp_out(input logic [COUNT_BITS-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    if (wide > 32'(mch_pkg::OUT_MAX)) return mch_pkg::OUT_MAX;
    return wide[OUT_BITS-1:0];
  endfunction

  // Apply one accepted item to the shadow histogram; queue the reply of a query.
  function automatic void track_item(input logic cmd, fs,
                                     input logic [CHAN_BITS-1:0] sel, a, b, c);
    hist_reply_t reply;
    logic [IDX_BITS-1:0] idx;
    idx = bin_index(a, b, c);
    if (cmd == mch_pkg::CMD_QUERY) begin
      // A query never clears, whatever its frame_start bit says.
      reply.bin_count    = clamp_out(hist_bins[idx]);
      reply.total_pixels = clamp_out(pixel_count);
      pending_replies.push_back(reply);
    end else begin
      if (fs) clear_histogram();
      if (sel == mch_pkg::SELECT_MARK) begin
        hist_bins[idx] = bump(hist_bins[idx]);
        pixel_count    = bump(pixel_count);
      end
    end
  endfunction

  // Offer one item, hold it until accepted, then maybe idle for a while.
  // Valid stays high when the next item follows at once.
  task automatic send_item(input logic cmd, fs, input logic [CHAN_BITS-1:0] sel, a, b, c);
    in_ch.valid          <= 1'b1;
    in_ch.cmd            <= cmd;
    in_ch.frame_start    <= fs;
    in_ch.pixel_selected <= sel;
    in_ch.chan_a         <= a;
    in_ch.chan_b         <= b;
    in_ch.chan_c         <= c;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    track_item(cmd, fs, sel, a, b, c);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Receiver: check each result against the oldest expectation, then pick
  // the next ready value (long hold-off first, else random stalls).
  initial begin
    hist_reply_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (pending_replies.size() == 0) begin
          note_failure("unexpected result, bin_count", 32'd0, 32'(out_ch.bin_count));
        end else begin
          want = pending_replies.pop_front();
          if (out_ch.bin_count !== want.bin_count)
            note_failure("bin_count", 32'(want.bin_count), 32'(out_ch.bin_count));
          if (out_ch.total_pixels !== want.total_pixels)
            note_failure("total_pixels", 32'(want.total_pixels),
                         32'(out_ch.total_pixels));
        end
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Watchdog: end the run if nothing moves on either side for too long.
  initial begin
    int stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stalled = 0;
      else
        stalled++;
    end
    $display("FAILURE");
    $finish;
  end

  // Queries on the reset state, then learning with no frame start at all.
  task automatic test_reset_state();
    send_item(mch_pkg::CMD_QUERY, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00);  // frame_start ignored
    send_item(mch_pkg::CMD_QUERY, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_item(mch_pkg::CMD_LEARN, 1'b0, mch_pkg::SELECT_MARK, 8'h12, 8'h34, 8'h56);
    // Same bin back to back exercises the write forwarding path.
    send_item(mch_pkg::CMD_LEARN, 1'b0, mch_pkg::SELECT_MARK, 8'h1F, 8'h3A, 8'h50);
    send_item(mch_pkg::CMD_QUERY, 1'b0, 8'h00, 8'h1C, 8'h33, 8'h5F);
  endtask

  // Frame clears, masks other than 255, bin edges, query right after learn.
  task automatic test_frame_clear();
    // Clear still happens when the frame-start pixel is not selected.
    send_item(mch_pkg::CMD_LEARN, 1'b1, 8'h00, 8'h12, 8'h34, 8'h56);
    send_item(mch_pkg::CMD_QUERY, 1'b0, 8'h00, 8'h12, 8'h34, 8'h56);
    send_item(mch_pkg::CMD_LEARN, 1'b1, mch_pkg::SELECT_MARK, 8'h00, 8'h00, 8'h00);
    send_item(mch_pkg::CMD_LEARN, 1'b0, 8'hFE, 8'h00, 8'h00, 8'h00);
    send_item(mch_pkg::CMD_LEARN, 1'b0, 8'h7F, 8'h00, 8'h00, 8'h00);
    send_item(mch_pkg::CMD_LEARN, 1'b0, 8'h80, 8'h00, 8'h00, 8'h00);
    send_item(mch_pkg::CMD_LEARN, 1'b0, mch_pkg::SELECT_MARK, 8'h0F, 8'h0F, 8'h0F);
    send_item(mch_pkg::CMD_QUERY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
    send_item(mch_pkg::CMD_LEARN, 1'b0, mch_pkg::SELECT_MARK, 8'h10, 8'h00, 8'h00);
    send_item(mch_pkg::CMD_QUERY, 1'b0, 8'h00, 8'h10, 8'h0F, 8'h0F);
    send_item(mch_pkg::CMD_QUERY, 1'b0, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_item(mch_pkg::CMD_LEARN, 1'b0, mch_pkg::SELECT_MARK, 8'hFF, 8'hFF, 8'hFF);
    send_item(mch_pkg::CMD_QUERY, 1'b1, 8'hFF, 8'hF0, 8'hF0, 8'hF0);
    send_item(mch_pkg::CMD_LEARN, 1'b0, mch_pkg::SELECT_MARK, 8'h00, 8'hFF, 8'h00);
    send_item(mch_pkg::CMD_LEARN, 1'b0, mch_pkg::SELECT_MARK, 8'h00, 8'h00, 8'hFF);
    send_item(mch_pkg::CMD_QUERY, 1'b0, 8'h00, 8'h00, 8'hF7, 8'h08);
    send_item(mch_pkg::CMD_QUERY, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFF);
    send_item(mch_pkg::CMD_QUERY, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
  endtask

  // Random frames: each opens with a frame start, then mostly selected pixels
  // drawn near a small palette (so bins build up), queries on those colors,
  // and some noise (random masks, random colors).
  task automatic test_random_frames(input int n_items, input int n_frames);
    logic [23:0] palette [6];
    logic [CHAN_BITS-1:0] a, b, c;
    int per_frame, pick, roll;
    per_frame = n_items / n_frames;
    for (int f = 0; f < n_frames; f++) begin
      foreach (palette[p]) palette[p] = 24'($urandom);
      send_item(mch_pkg::CMD_LEARN, 1'b1,
                ($urandom_range(3) == 0) ? 8'($urandom) : mch_pkg::SELECT_MARK,
                8'($urandom), 8'($urandom), 8'($urandom));
      for (int i = 1; i < per_frame; i++) begin
        roll = $urandom_range(99);
        pick = $urandom_range(5);
        a = (palette[pick][23:16] & BIN_MASK) | (8'($urandom) & ~BIN_MASK);
        b = (palette[pick][15:8]  & BIN_MASK) | (8'($urandom) & ~BIN_MASK);
        c = (palette[pick][7:0]   & BIN_MASK) | (8'($urandom) & ~BIN_MASK);
        if (roll < 55)
          send_item(mch_pkg::CMD_LEARN, 1'b0, mch_pkg::SELECT_MARK, a, b, c);
        else if (roll < 65)
          send_item(mch_pkg::CMD_LEARN, 1'b0, 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom));
        else if (roll < 88)
          send_item(mch_pkg::CMD_QUERY, 1'($urandom), 8'($urandom), a, b, c);
        else if (roll < 95)
          send_item(mch_pkg::CMD_QUERY, 1'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom));
        else
          send_item(mch_pkg::CMD_LEARN, 1'b0, mch_pkg::SELECT_MARK, 8'($urandom),
                    8'($urandom), 8'($urandom));
      end
    end
  endtask

  // Receiver holds off for a long stretch while queries keep coming, so the
  // result path fills and the input must stall.
  task automatic test_backpressure(input int n_items);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    holdoff_left = 400;
    for (int i = 0; i < n_items; i++) begin
      if (i % 8 == 7)
        send_item(mch_pkg::CMD_LEARN, 1'b0, mch_pkg::SELECT_MARK, 8'($urandom),
                  8'($urandom), 8'($urandom));
      else
        send_item(mch_pkg::CMD_QUERY, 1'b0, 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
    end
  endtask

  initial begin
    in_ch.valid          = 1'b0;
    in_ch.cmd            = mch_pkg::CMD_LEARN;
    in_ch.frame_start    = 1'b0;
    in_ch.pixel_selected = '0;
    in_ch.chan_a         = '0;
    in_ch.chan_b         = '0;
    in_ch.chan_c         = '0;
    clear_histogram();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_frame_clear();

    // Random part over the idling phases: none, sender, receiver, both.
    src_idle_pct = 0;  snk_idle_pct = 0;
    test_random_frames(480, 2);
    src_idle_pct = 59; snk_idle_pct = 0;
    test_random_frames(480, 2);
    src_idle_pct = 0;  snk_idle_pct = 59;
    test_random_frames(480, 2);
    src_idle_pct = 25; snk_idle_pct = 25;
    test_random_frames(480, 2);

    test_backpressure(64);

    // Drop valid, drain the remaining results, then let the pipe settle.
    in_ch.valid <= 1'b0;
    snk_idle_pct = 0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0)
      note_failure("results still missing", 32'd0, 32'(pending_replies.size()));

    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
